@@ hdl/bir_pkg.sv @@
// ----------------------------------------------------------------------------
// bir_pkg
// Shared widths, sizes and register codes of the bilinear image resizer.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 4;

  localparam int COL_W      = 8;
  localparam int ROW_W      = 8;
  localparam int PLANE_W    = 2;
  localparam int PIX_W      = 8;
  localparam int OUT_W      = 16;
  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ADDR_W     = ROW_W + COL_W + PLANE_W;

  localparam int PROD_W  = 2 * STEP_W;
  localparam int POS_W   = STEP_W + COL_W;
  localparam int HACC_W  = PIX_W + FRAC_W;
  localparam int VACC_W  = HACC_W + FRAC_W;
  localparam int WGT_W   = FRAC_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP      = 3'd5;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [PIX_W-1:0]        wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
  } bir_store_req_t;

endpackage

@@ hdl/bir_channels.sv @@
// ----------------------------------------------------------------------------
// bir_channels
// Valid/ready channel interfaces of the resizer: input words, result words
// and configuration writes.
// ----------------------------------------------------------------------------
interface bir_in_if import bir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [PLANE_W-1:0] plane;
  logic [PIX_W-1:0]   pixel_in;

  modport source (output valid, operation, column, row, plane, pixel_in, input ready);
  modport sink   (input valid, operation, column, row, plane, pixel_in, output ready);
endinterface

interface bir_out_if import bir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pixel_out;
  logic             out_of_range;

  modport source (output valid, pixel_out, out_of_range, input ready);
  modport sink   (input valid, pixel_out, out_of_range, output ready);
endinterface

interface bir_cfg_if import bir_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/bir_frame_store.sv @@
// ----------------------------------------------------------------------------
// bir_frame_store
// Single-port-write, single-port-read byte store of the source frame,
// registered read data.
// ----------------------------------------------------------------------------
module bir_frame_store import bir_pkg::*; (
  input  logic             clk,
  input  bir_store_req_t   req,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ hdl/bilinear_image_resize.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Two-pass bilinear scaler over a byte frame store, one shared multiplier.
// ----------------------------------------------------------------------------
// A load word writes one source byte; the block is ready again on the next
// cycle. A request word runs a sequencer around a single 24x24 multiplier:
// column position, row position, geometry, then per source row two
// frame-store reads with two horizontal multiplies and one vertical multiply.
// After a request is accepted the input stays not ready until its result has
// been loaded into the result register, which waits for that register to
// empty; a second source row is read and blended only when needed.
// Out-of-range requests go straight to the result stage. The frame store has
// no reset; reading a location never loaded returns unspecified data. Source
// sizes of 0 act as 1, larger than 256 as 256.
// ----------------------------------------------------------------------------
module bilinear_image_resize import bir_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  bir_in_if.sink        in_ch,
  bir_out_if.source     out_ch,
  bir_cfg_if.sink       cfg_ch
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL_X = 9'b000000010,
    ST_MUL_Y = 9'b000000100,
    ST_GEO   = 9'b000001000,
    ST_RD0   = 9'b000010000,
    ST_RD1   = 9'b000100000,
    ST_HM1   = 9'b001000000,
    ST_VM    = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [STEP_W-1:0] col_step_r, row_step_r;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic               oor_r, oor_nxt;
  logic [POS_W-1:0]   prod_r, prod_nxt;
  logic [COL_W-1:0]   ix_r, ix_nxt, ix1_r, ix1_nxt;
  logic [FRAC_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [ROW_W-1:0]   iy_r, iy_nxt, iy1_r, iy1_nxt;
  logic               two_rows_r, two_rows_nxt;
  logic               row_sel_r, row_sel_nxt;
  logic [HACC_W-1:0]  acc_h_r, acc_h_nxt;
  logic [VACC_W-1:0]  acc_v_r, acc_v_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_pix_r, out_pix_nxt;
  logic               out_oor_r, out_oor_nxt;

  logic [STEP_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  logic [SIZE_W-1:0] sw, sh, last_col, last_row;
  logic [FRAC_W-1:0] int_pos;
  logic [SIZE_W-1:0] ix_inc, iy_inc;
  logic [WGT_W-1:0]  wx0, wy0;
  logic [ROW_W-1:0]  y_cur;
  logic              in_acc, out_load, req_oor;

  bir_store_req_t    store_req;
  logic [PIX_W-1:0]  rd_data;

  bir_frame_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r    <= SIZE_W'(1);
      src_h_r    <= SIZE_W'(1);
      tgt_w_r    <= SIZE_W'(1);
      tgt_h_r    <= SIZE_W'(1);
      col_step_r <= '0;
      row_step_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SOURCE_WIDTH:  src_w_r    <= cfg_ch.data[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: src_h_r    <= cfg_ch.data[SIZE_W-1:0];
        CFG_TARGET_WIDTH:  tgt_w_r    <= cfg_ch.data[SIZE_W-1:0];
        CFG_TARGET_HEIGHT: tgt_h_r    <= cfg_ch.data[SIZE_W-1:0];
        CFG_COLUMN_STEP:   col_step_r <= cfg_ch.data[STEP_W-1:0];
        CFG_ROW_STEP:      row_step_r <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped source sizes
  always_comb begin
    if (src_w_r == '0) begin
      sw = SIZE_W'(1);
    end else if (32'(src_w_r) > MAX_WIDTH) begin
      sw = SIZE_W'(MAX_WIDTH);
    end else begin
      sw = src_w_r;
    end
    if (src_h_r == '0) begin
      sh = SIZE_W'(1);
    end else if (32'(src_h_r) > MAX_HEIGHT) begin
      sh = SIZE_W'(MAX_HEIGHT);
    end else begin
      sh = src_h_r;
    end
  end

  assign last_col = sw - SIZE_W'(1);
  assign last_row = sh - SIZE_W'(1);
  assign int_pos  = prod_r[POS_W-1:FRAC_W];
  assign wx0      = WGT_W'(1 << FRAC_W) - WGT_W'(dx_r);
  assign wy0      = WGT_W'(1 << FRAC_W) - WGT_W'(dy_r);
  assign y_cur    = row_sel_r ? iy1_r : iy_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign req_oor = ({1'b0, in_ch.column} >= tgt_w_r) || ({1'b0, in_ch.row} >= tgt_h_r) ||
                   (32'(in_ch.plane) >= MAX_CHANNELS);

  // shared multiplier
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    plane_nxt    = plane_r;
    oor_nxt      = oor_r;
    prod_nxt     = prod_r;
    ix_nxt       = ix_r;
    ix1_nxt      = ix1_r;
    dx_nxt       = dx_r;
    iy_nxt       = iy_r;
    iy1_nxt      = iy1_r;
    dy_nxt       = dy_r;
    two_rows_nxt = two_rows_r;
    row_sel_nxt  = row_sel_r;
    acc_h_nxt    = acc_h_r;
    acc_v_nxt    = acc_v_r;
    mul_a        = '0;
    mul_b        = '0;
    ix_inc       = '0;
    iy_inc       = '0;

    store_req.wr_en   = 1'b0;
    store_req.wr_addr = {in_ch.row, in_ch.column, in_ch.plane};
    store_req.wr_data = in_ch.pixel_in;
    store_req.rd_en   = 1'b0;
    store_req.rd_addr = {y_cur, ix_r, plane_r};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          col_nxt   = in_ch.column;
          row_nxt   = in_ch.row;
          plane_nxt = in_ch.plane;
          if (in_ch.operation == OP_LOAD) begin
            store_req.wr_en = (32'(in_ch.column) < MAX_WIDTH) &&
                              (32'(in_ch.row) < MAX_HEIGHT) &&
                              (32'(in_ch.plane) < MAX_CHANNELS);
          end else if (req_oor) begin
            oor_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            oor_nxt   = 1'b0;
            state_nxt = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        mul_a     = col_step_r;
        mul_b     = STEP_W'(col_r);
        prod_nxt  = mul_p[POS_W-1:0];
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        // horizontal geometry from column position
        mul_a    = row_step_r;
        mul_b    = STEP_W'(row_r);
        prod_nxt = mul_p[POS_W-1:0];
        if (({1'b0, col_r} == tgt_w_r - SIZE_W'(1)) || (sw == SIZE_W'(1))) begin
          ix_nxt  = last_col[COL_W-1:0];
          ix1_nxt = last_col[COL_W-1:0];
          dx_nxt  = '0;
        end else begin
          ix_nxt  = (int_pos > FRAC_W'(last_col)) ? last_col[COL_W-1:0]
                                                  : int_pos[COL_W-1:0];
          ix_inc  = SIZE_W'(ix_nxt) + SIZE_W'(1);
          ix1_nxt = (ix_inc > last_col) ? last_col[COL_W-1:0] : ix_inc[COL_W-1:0];
          dx_nxt  = prod_r[FRAC_W-1:0];
        end
        state_nxt = ST_GEO;
      end
      ST_GEO: begin
        iy_nxt       = (int_pos > FRAC_W'(last_row)) ? last_row[ROW_W-1:0]
                                                     : int_pos[ROW_W-1:0];
        iy_inc       = SIZE_W'(iy_nxt) + SIZE_W'(1);
        iy1_nxt      = (iy_inc > last_row) ? last_row[ROW_W-1:0] : iy_inc[ROW_W-1:0];
        dy_nxt       = prod_r[FRAC_W-1:0];
        two_rows_nxt = !(({1'b0, row_r} == tgt_h_r - SIZE_W'(1)) || (sh == SIZE_W'(1)));
        row_sel_nxt  = 1'b0;
        state_nxt    = ST_RD0;
      end
      ST_RD0: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = {y_cur, ix_r, plane_r};
        state_nxt         = ST_RD1;
      end
      ST_RD1: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = {y_cur, ix1_r, plane_r};
        mul_a             = STEP_W'(rd_data);
        mul_b             = STEP_W'(wx0);
        acc_h_nxt         = mul_p[HACC_W-1:0];
        state_nxt         = ST_HM1;
      end
      ST_HM1: begin
        mul_a     = STEP_W'(rd_data);
        mul_b     = STEP_W'(dx_r);
        acc_h_nxt = acc_h_r + mul_p[HACC_W-1:0];
        state_nxt = ST_VM;
      end
      ST_VM: begin
        mul_a     = acc_h_r;
        mul_b     = row_sel_r ? STEP_W'(dy_r) : STEP_W'(wy0);
        acc_v_nxt = (row_sel_r ? acc_v_r : '0) + mul_p[VACC_W-1:0];
        if (!row_sel_r && two_rows_r) begin
          row_sel_nxt = 1'b1;
          state_nxt   = ST_RD0;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_oor_nxt   = out_oor_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_oor_nxt   = oor_r;
      out_pix_nxt   = oor_r ? '0 : acc_v_r[VACC_W-1:VACC_W-OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    plane_r    <= plane_nxt;
    oor_r      <= oor_nxt;
    prod_r     <= prod_nxt;
    ix_r       <= ix_nxt;
    ix1_r      <= ix1_nxt;
    dx_r       <= dx_nxt;
    iy_r       <= iy_nxt;
    iy1_r      <= iy1_nxt;
    dy_r       <= dy_nxt;
    two_rows_r <= two_rows_nxt;
    row_sel_r  <= row_sel_nxt;
    acc_h_r    <= acc_h_nxt;
    acc_v_r    <= acc_v_nxt;
    out_pix_r  <= out_pix_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_out    = out_pix_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear image resizer. A directed table covers
// reset defaults, pixel extremes, edge columns and rows, clamped source sizes,
// saturating steps and out-of-range requests. Random phases follow, each with
// a fresh register setting. Every request first loads any source pixel it
// would read, so the frame store is never read before it is written. Results
// are predicted in the bench and compared in order; both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bir_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_WORDS   = 230;
  localparam int TARGET_WORDS  = 1900;

  typedef enum logic [1:0] {DO_CFG, DO_LOAD, DO_REQ} action_t;

  typedef struct packed {
    action_t              kind;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [PLANE_W-1:0]   plane;
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 known;
    logic [OUT_W-1:0]     pix;
    logic                 oor;
  } plan_t;

  typedef struct packed {
    logic               op;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
    logic [PIX_W-1:0]   pix;
  } word_t;

  typedef struct packed {
    logic [OUT_W-1:0] pix;
    logic             oor;
  } result_t;

  typedef struct {
    int unsigned sw, sh;
    int unsigned ix, ix1, iy, iy1;
    int unsigned dx, dy;
    bit          last_col, single_row;
  } taps_t;

  logic clk;
  logic rst_n;

  bir_in_if  in_ch ();
  bir_out_if out_ch ();
  bir_cfg_if cfg_ch ();

  bilinear_image_resize i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [PIX_W-1:0]      frame [0:MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS-1];
  bit                    loaded [0:MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS-1];
  logic [SIZE_W-1:0]     src_w = 1, src_h = 1, tgt_w = 1, tgt_h = 1;
  logic [STEP_W-1:0]     col_step = 0, row_step = 0;
  result_t               due_pixels [$];

  bit steady = 1'b0;
  int errors = 0;
  int n_loads = 0, n_requests = 0, n_checked = 0, n_oor = 0, n_settings = 0;
  int quiet_cycles = 0;

  plan_t plan [$] = '{
    '{DO_LOAD, 8'd0,   8'd0,   2'd0, 24'hff,     CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_LOAD, 8'd0,   8'd0,   2'd3, 24'h00,     CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd0,   8'd0,   2'd0, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'hff00, 1'b0},
    '{DO_REQ,  8'd0,   8'd0,   2'd3, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'h0000, 1'b0},
    '{DO_REQ,  8'd255, 8'd255, 2'd1, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'h0,    1'b1},
    '{DO_REQ,  8'd1,   8'd0,   2'd2, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'h0,    1'b1},
    '{DO_REQ,  8'd0,   8'd1,   2'd2, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'h0,    1'b1},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd2,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd2,      CFG_SOURCE_HEIGHT, 1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd3,      CFG_TARGET_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd3,      CFG_TARGET_HEIGHT, 1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'h8000,   CFG_COLUMN_STEP,   1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'h8000,   CFG_ROW_STEP,      1'b0, 16'h0,    1'b0},
    '{DO_LOAD, 8'd0,   8'd0,   2'd2, 24'h10,     CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_LOAD, 8'd1,   8'd0,   2'd2, 24'hf0,     CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_LOAD, 8'd0,   8'd1,   2'd2, 24'h80,     CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_LOAD, 8'd1,   8'd1,   2'd2, 24'h01,     CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd1,   8'd1,   2'd2, 24'h0,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd2,   8'd2,   2'd2, 24'h0,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd0,   8'd2,   2'd2, 24'h0,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd3,   8'd0,   2'd2, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'h0,    1'b1},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd0,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd511,    CFG_SOURCE_HEIGHT, 1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd256,    CFG_TARGET_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd256,    CFG_TARGET_HEIGHT, 1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'hffffff, CFG_COLUMN_STEP,   1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'hffffff, CFG_ROW_STEP,      1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd255, 8'd255, 2'd1, 24'h0,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd128, 8'd7,   2'd0, 24'h0,      CFG_SOURCE_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_CFG,  8'd0,   8'd0,   2'd0, 24'd0,      CFG_TARGET_WIDTH,  1'b0, 16'h0,    1'b0},
    '{DO_REQ,  8'd0,   8'd0,   2'd0, 24'h0,      CFG_SOURCE_WIDTH,  1'b1, 16'h0,    1'b1}
  };

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned pel_addr(int unsigned x, int unsigned y, int unsigned k);
    return (y * MAX_WIDTH + x) * MAX_CHANNELS + k;
  endfunction

  function automatic taps_t locate_taps(word_t w);
    taps_t t;
    longint unsigned sx, sy;
    t.sw = clamp_size(src_w, MAX_WIDTH);
    t.sh = clamp_size(src_h, MAX_HEIGHT);
    sx = 64'(w.col) * 64'(col_step);
    sy = 64'(w.row) * 64'(row_step);
    t.dx = 32'(sx[15:0]);
    t.dy = 32'(sy[15:0]);
    t.ix = ((sx >> 16) > t.sw - 1) ? t.sw - 1 : 32'(sx >> 16);
    t.iy = ((sy >> 16) > t.sh - 1) ? t.sh - 1 : 32'(sy >> 16);
    t.ix1 = (t.ix + 1 > t.sw - 1) ? t.sw - 1 : t.ix + 1;
    t.iy1 = (t.iy + 1 > t.sh - 1) ? t.sh - 1 : t.iy + 1;
    t.last_col = (32'(w.col) == 32'(tgt_w) - 1) || (t.sw == 1);
    t.single_row = (32'(w.row) == 32'(tgt_h) - 1) || (t.sh == 1);
    return t;
  endfunction

  function automatic longint unsigned blend_row(taps_t t, int unsigned y, int unsigned k);
    if (t.last_col) return 64'(frame[pel_addr(t.sw - 1, y, k)]) << 16;
    return 64'(frame[pel_addr(t.ix, y, k)]) * (65536 - t.dx) +
           64'(frame[pel_addr(t.ix1, y, k)]) * t.dx;
  endfunction

  function automatic result_t resize_pixel(word_t w);
    result_t r;
    taps_t t;
    longint unsigned v;
    r.pix = '0;
    r.oor = 1'b1;
    if (w.col >= tgt_w || w.row >= tgt_h) return r;
    t = locate_taps(w);
    v = blend_row(t, t.iy, w.plane) * (65536 - t.dy);
    if (!t.single_row) v += blend_row(t, t.iy1, w.plane) * t.dy;
    r.pix = v[39:24];
    r.oor = 1'b0;
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] step_for(int unsigned src, int unsigned tgt,
                                                 int unsigned maxv);
    int unsigned s;
    longint unsigned q;
    s = clamp_size(src, maxv);
    if ($urandom_range(99) < 25) return STEP_W'($urandom);
    if ($urandom_range(99) < 5) return '1;
    if (tgt < 2) return '0;
    q = (64'(s - 1) << 16) / (tgt - 1);
    return q[STEP_W-1:0];
  endfunction

  function automatic logic [7:0] pick_coord(int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(99);
    if (limit == 0 || limit > 256 || roll < 10) return 8'($urandom_range(0, 255));
    if (roll < 22) return 8'(limit - 1);
    return 8'($urandom_range(0, limit - 1));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic send_word(word_t w, bit known, result_t given);
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= w.op;
    in_ch.column    <= w.col;
    in_ch.row       <= w.row;
    in_ch.plane     <= w.plane;
    in_ch.pixel_in  <= w.pix;
    do @(posedge clk); while (!in_ch.ready);
    if (w.op == OP_LOAD) begin
      frame[pel_addr(w.col, w.row, w.plane)]  = w.pix;
      loaded[pel_addr(w.col, w.row, w.plane)] = 1'b1;
      n_loads++;
    end else begin
      due_pixels = {due_pixels, known ? given : resize_pixel(w)};
      n_requests++;
    end
  endtask

  // load every source pixel a request may touch that holds no data yet
  task automatic fill_taps(word_t req);
    taps_t t;
    int unsigned cols [3];
    int unsigned rows [2];
    word_t ld;
    if (req.col >= tgt_w || req.row >= tgt_h) return;
    t = locate_taps(req);
    cols = '{t.ix, t.ix1, t.sw - 1};
    rows = '{t.iy, t.iy1};
    foreach (rows[j]) begin
      foreach (cols[i]) begin
        if (!loaded[pel_addr(cols[i], rows[j], req.plane)]) begin
          ld.op    = OP_LOAD;
          ld.col   = 8'(cols[i]);
          ld.row   = 8'(rows[j]);
          ld.plane = req.plane;
          ld.pix   = 8'($urandom);
          send_word(ld, 1'b0, '0);
        end
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_SOURCE_WIDTH:  src_w = data[SIZE_W-1:0];
      CFG_SOURCE_HEIGHT: src_h = data[SIZE_W-1:0];
      CFG_TARGET_WIDTH:  tgt_w = data[SIZE_W-1:0];
      CFG_TARGET_HEIGHT: tgt_h = data[SIZE_W-1:0];
      CFG_COLUMN_STEP:   col_step = data[STEP_W-1:0];
      CFG_ROW_STEP:      row_step = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  // drain all pending pixels, then let a trailing load finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_pixels.size() == 0) begin
        report_mismatch("unexpected word", out_ch.pixel_out, 0);
      end else begin
        want = due_pixels.pop_front();
        n_checked++;
        if (want.oor) n_oor++;
        if (out_ch.pixel_out !== want.pix) report_mismatch("pixel_out", out_ch.pixel_out, want.pix);
        if (out_ch.out_of_range !== want.oor)
          report_mismatch("out_of_range", out_ch.out_of_range, want.oor);
      end
    end
    out_ch.ready <= steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles at %0t", IDLE_LIMIT, $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    plan_t p;
    word_t w;
    bit cfg_open;
    int phase;
    int unsigned sw, sh, tw, th;
    logic [STEP_W-1:0] cs, rs;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.column    <= '0;
    in_ch.row       <= '0;
    in_ch.plane     <= '0;
    in_ch.pixel_in  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_SOURCE_WIDTH;
    cfg_ch.data     <= '0;
    cfg_open = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      p = plan[i];
      if (p.kind == DO_CFG) begin
        if (!cfg_open) begin
          settle();
          n_settings++;
        end
        write_reg(p.reg_idx, p.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_ch.valid <= 1'b0;
        cfg_open = 1'b0;
        w.op    = (p.kind == DO_LOAD) ? OP_LOAD : OP_REQUEST;
        w.col   = p.col;
        w.row   = p.row;
        w.plane = p.plane;
        w.pix   = p.data[PIX_W-1:0];
        if (p.kind == DO_REQ) fill_taps(w);
        send_word(w, p.known, result_t'{p.pix, p.oor});
      end
    end

    phase = 0;
    while (n_loads + n_requests < TARGET_WORDS) begin
      case (phase)
        0: begin
          sw = 256; sh = 256; tw = 256; th = 256;
        end
        1: begin
          sw = 1; sh = 1; tw = $urandom_range(1, 64); th = $urandom_range(1, 64);
        end
        2: begin
          sw = 0; sh = 0; tw = 1; th = 1;
        end
        3: begin
          sw = 511; sh = 257; tw = 511; th = 300;
        end
        default: begin
          sw = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(0, 511);
          sh = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(0, 511);
          tw = ($urandom_range(99) < 80) ? $urandom_range(1, 40) : $urandom_range(0, 511);
          th = ($urandom_range(99) < 80) ? $urandom_range(1, 40) : $urandom_range(0, 511);
        end
      endcase
      cs = step_for(sw, tw, MAX_WIDTH);
      rs = step_for(sh, th, MAX_HEIGHT);
      steady = (phase == 1);
      settle();
      n_settings++;
      write_reg(CFG_SOURCE_WIDTH,  {($urandom_range(99) < 30) ? 15'($urandom) : 15'd0, 9'(sw)});
      write_reg(CFG_SOURCE_HEIGHT, {($urandom_range(99) < 30) ? 15'($urandom) : 15'd0, 9'(sh)});
      write_reg(CFG_TARGET_WIDTH,  {($urandom_range(99) < 30) ? 15'($urandom) : 15'd0, 9'(tw)});
      write_reg(CFG_TARGET_HEIGHT, {($urandom_range(99) < 30) ? 15'($urandom) : 15'd0, 9'(th)});
      write_reg(CFG_COLUMN_STEP, cs);
      write_reg(CFG_ROW_STEP, rs);
      cfg_ch.valid <= 1'b0;

      for (int i = 0; i < PHASE_WORDS && n_loads + n_requests < TARGET_WORDS; i++) begin
        w.plane = 2'($urandom);
        w.pix   = 8'($urandom);
        if ($urandom_range(99) < 35) begin
          w.op = OP_LOAD;
          if ($urandom_range(1) == 1) begin
            w.col = 8'($urandom_range(0, clamp_size(src_w, MAX_WIDTH) - 1));
            w.row = 8'($urandom_range(0, clamp_size(src_h, MAX_HEIGHT) - 1));
          end else begin
            w.col = 8'($urandom);
            w.row = 8'($urandom);
          end
        end else begin
          w.op  = OP_REQUEST;
          w.col = pick_coord(tgt_w);
          w.row = pick_coord(tgt_h);
          fill_taps(w);
        end
        send_word(w, 1'b0, '0);
      end
      phase++;
    end
    steady = 1'b0;
    settle();

    $display("covered %0d pixel loads and %0d requests over %0d register settings",
             n_loads, n_requests, n_settings);
    $display("checked %0d result words, %0d of them out of range", n_checked, n_oor);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
